/* rtl/core/smcg_pkg.sv */
// ---------------------------------------------------------------------------
// smcg_pkg
// Shared types, register codes and the quarter-wave sine builder for the
// sphere mesh cell generator.
// ---------------------------------------------------------------------------
package smcg_pkg;

  localparam int unsigned IDX_W = 9;
  localparam int unsigned CNT_W = 9;
  localparam int unsigned RAD_W = 16;
  localparam int unsigned MAG_W = 15;
  localparam int unsigned POS_W = 17;
  localparam int unsigned NRM_W = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd2;

  localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
  localparam logic [CNT_W-1:0] STACKS_RST = 9'd8;
  localparam logic [CNT_W-1:0] SLICES_RST = 9'd8;

  // vertex sequence: first triangle occupies slots 0..2, second 3..5
  localparam logic [2:0] VTX_FIRST_LO  = 3'd0;
  localparam logic [2:0] VTX_FIRST_HI  = 3'd2;
  localparam logic [2:0] VTX_SECOND_LO = 3'd3;
  localparam logic [2:0] VTX_SECOND_HI = 3'd5;

  // corner of each slot: bit 1 selects the longitude edge, bit 0 the latitude edge
  localparam logic [1:0] VTX_CORNER [6] = '{2'b00, 2'b01, 2'b10, 2'b01, 2'b10, 2'b11};

  typedef struct packed {
    logic v;
    logic first;
    logic second;
  } meta_t;

  // Q0.15 magnitude of sin(pi/2 * k / 2^lg), Q30 Taylor series
  function automatic logic [MAG_W-1:0] quarter_sine(input int unsigned k,
                                                    input int unsigned lg);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    x    = (64'd1686629713 * 64'(k) + (64'd1 << (lg - 1))) >> lg;
    x2   = (x * x + (64'd1 << 29)) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 272; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    r = (longint'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) r = 64'd32767;
    return r[MAG_W-1:0];
  endfunction

endpackage

/* rtl/core/smcg_div_pipe.sv */
// ---------------------------------------------------------------------------
// smcg_div_pipe
// Restoring divider, one quotient bit per register stage.
// ---------------------------------------------------------------------------
module smcg_div_pipe #(
  parameter int unsigned NW = 21,
  parameter int unsigned VW = 9
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [VW-1:0] den,
  output logic [NW-1:0] quo
);

  logic [VW-1:0] rem_r   [NW];
  logic [NW-1:0] acc_r   [NW];
  logic [VW-1:0] den_r   [NW];
  logic [VW-1:0] rem_nxt [NW];
  logic [NW-1:0] acc_nxt [NW];
  logic [VW-1:0] rem_in  [NW];
  logic [NW-1:0] acc_in  [NW];
  logic [VW-1:0] den_in  [NW];

  always_comb begin
    logic [VW:0] t;
    logic        qb;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        rem_in[s] = '0;
        acc_in[s] = num;
        den_in[s] = den;
      end else begin
        rem_in[s] = rem_r[s-1];
        acc_in[s] = acc_r[s-1];
        den_in[s] = den_r[s-1];
      end
      t  = {rem_in[s], acc_in[s][NW-1]};
      qb = (t >= {1'b0, den_in[s]});
      if (qb) begin
        rem_nxt[s] = VW'(t - {1'b0, den_in[s]});
      end else begin
        rem_nxt[s] = t[VW-1:0];
      end
      acc_nxt[s] = {acc_in[s][NW-2:0], qb};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < NW; s++) begin
        rem_r[s] <= rem_nxt[s];
        acc_r[s] <= acc_nxt[s];
        den_r[s] <= den_in[s];
      end
    end
  end

  assign quo = acc_r[NW-1];

endmodule

/* rtl/core/smcg_sine_rom.sv */
// ---------------------------------------------------------------------------
// smcg_sine_rom
// Quarter-wave sine table, DEPTH+1 entries of Q0.15 magnitude, registered read.
// ---------------------------------------------------------------------------
module smcg_sine_rom #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [$clog2(DEPTH):0]        addr,
  output logic [smcg_pkg::MAG_W-1:0]    data
);
  import smcg_pkg::*;

  localparam int unsigned LG = $clog2(DEPTH);

  typedef logic [MAG_W-1:0] tbl_t [DEPTH+1];

  function automatic tbl_t build_tbl();
    tbl_t t;
    for (int k = 0; k <= DEPTH; k++) begin
      t[k] = quarter_sine(k, LG);
    end
    return t;
  endfunction

  localparam tbl_t TBL = build_tbl();

  logic [MAG_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= TBL[addr];
    end
  end

  assign data = data_r;

endmodule

/* rtl/core/sphere_mesh_cell_generator.sv */
// ---------------------------------------------------------------------------
// sphere_mesh_cell_generator
// Latitude/longitude sphere tessellation: one grid cell in, up to six
// vertices (position and unit normal) out.
// ---------------------------------------------------------------------------
// Pipeline: entry register, DW divider stages, table read, normal, position
//   and emit registers, where DW = 11 + log2(SINE_TABLE_DEPTH) is the divider
//   depth (21 stages at 1024).
// Throughput: one vertex per cycle on the result port while out_ready is high;
//   a cell gives 6 vertices (3 on the first or last stack), a dropped cell none.
// Reset: synchronous, active low; radius 256, 8 stacks, 8 slices, pipe empty.
module sphere_mesh_cell_generator #(
  parameter int unsigned MAX_STACKS       = 256,
  parameter int unsigned MAX_SLICES       = 256,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [smcg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [smcg_pkg::CFG_DAT_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [smcg_pkg::IDX_W-1:0]           in_stack_index,
  input  logic [smcg_pkg::IDX_W-1:0]           in_slice_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [smcg_pkg::POS_W-1:0]    out_pos_x,
  output logic signed [smcg_pkg::POS_W-1:0]    out_pos_y,
  output logic signed [smcg_pkg::POS_W-1:0]    out_pos_z,
  output logic signed [smcg_pkg::NRM_W-1:0]    out_norm_x,
  output logic signed [smcg_pkg::NRM_W-1:0]    out_norm_y,
  output logic signed [smcg_pkg::NRM_W-1:0]    out_norm_z,
  output logic                                 out_last_vertex
);
  import smcg_pkg::*;

  localparam int unsigned LG = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned PW = LG + 2;          // phase width, full circle
  localparam int unsigned AW = LG + 1;          // table address width
  localparam int unsigned DW = IDX_W + LG + 2;  // dividend / divider depth

  // -------------------------------------------------------------------------
  // Configuration registers; always ready, unknown indexes are dropped
  // -------------------------------------------------------------------------
  logic [RAD_W-1:0] radius_r;
  logic [CNT_W-1:0] stacks_r;
  logic [CNT_W-1:0] slices_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      stacks_r <= STACKS_RST;
      slices_r <= SLICES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RADIUS: radius_r <= cfg_data;
        CFG_STACKS: stacks_r <= cfg_data[CNT_W-1:0];
        CFG_SLICES: slices_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // -------------------------------------------------------------------------
  // Global advance: the whole pipe moves when the emit stage can take a cell
  // -------------------------------------------------------------------------
  logic adv;
  logic e_v_r;
  logic e_last;

  assign adv      = !e_v_r || (out_ready && e_last);
  assign in_ready = adv;

  // -------------------------------------------------------------------------
  // Entry stage: clamp counts, check range, form the four dividends
  // -------------------------------------------------------------------------
  logic [CNT_W-1:0] n_eff;
  logic [CNT_W-1:0] m_eff;
  logic             idx_ok;
  meta_t            ent_meta;
  logic [IDX_W-1:0] i_m1;
  logic [IDX_W-1:0] j_m1;

  always_comb begin
    n_eff  = (32'(stacks_r) > MAX_STACKS) ? CNT_W'(MAX_STACKS) : stacks_r;
    m_eff  = (32'(slices_r) > MAX_SLICES) ? CNT_W'(MAX_SLICES) : slices_r;
    idx_ok = (n_eff != '0) && (m_eff != '0) &&
             (in_stack_index != '0) && (in_slice_index != '0) &&
             (in_stack_index <= n_eff) && (in_slice_index <= m_eff);
    ent_meta.first  = (in_stack_index > IDX_W'(1));
    ent_meta.second = (in_stack_index < n_eff);
    // a single-stack sphere skips both triangles: drop it here
    ent_meta.v = in_valid && idx_ok && (ent_meta.first || ent_meta.second);
    i_m1 = in_stack_index - IDX_W'(1);
    j_m1 = in_slice_index - IDX_W'(1);
  end

  meta_t            s0_meta_r;
  logic [DW-1:0]    s0_num_r [4];
  logic [CNT_W-1:0] s0_n_r;
  logic [CNT_W-1:0] s0_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_meta_r <= '0;
    end else if (adv) begin
      s0_meta_r <= ent_meta;
    end
  end

  // half the divisor is added to round the quotient half up
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_num_r[0] <= (DW'(i_m1) << (LG + 1)) + DW'(n_eff >> 1);
      s0_num_r[1] <= (DW'(in_stack_index) << (LG + 1)) + DW'(n_eff >> 1);
      s0_num_r[2] <= (DW'(j_m1) << (LG + 2)) + DW'(m_eff >> 1);
      s0_num_r[3] <= (DW'(in_slice_index) << (LG + 2)) + DW'(m_eff >> 1);
      s0_n_r      <= n_eff;
      s0_m_r      <= m_eff;
    end
  end

  // -------------------------------------------------------------------------
  // Dividers: lat0, lat1 by the stack count; lon0, lon1 by the slice count
  // -------------------------------------------------------------------------
  logic [DW-1:0] quo [4];

  smcg_div_pipe #(.NW(DW), .VW(CNT_W)) u_div_lat0 (
    .clk(clk), .en(adv), .num(s0_num_r[0]), .den(s0_n_r), .quo(quo[0]));
  smcg_div_pipe #(.NW(DW), .VW(CNT_W)) u_div_lat1 (
    .clk(clk), .en(adv), .num(s0_num_r[1]), .den(s0_n_r), .quo(quo[1]));
  smcg_div_pipe #(.NW(DW), .VW(CNT_W)) u_div_lon0 (
    .clk(clk), .en(adv), .num(s0_num_r[2]), .den(s0_m_r), .quo(quo[2]));
  smcg_div_pipe #(.NW(DW), .VW(CNT_W)) u_div_lon1 (
    .clk(clk), .en(adv), .num(s0_num_r[3]), .den(s0_m_r), .quo(quo[3]));

  // valid and triangle flags travel alongside the divider stages
  meta_t div_meta_r [DW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DW; s++) div_meta_r[s] <= '0;
    end else if (adv) begin
      div_meta_r[0] <= s0_meta_r;
      for (int s = 1; s < DW; s++) div_meta_r[s] <= div_meta_r[s-1];
    end
  end

  // -------------------------------------------------------------------------
  // Phase stage: fold each phase onto the quarter wave, read the tables
  // -------------------------------------------------------------------------
  logic [PW-1:0] ph    [4];
  logic [AW-1:0] s_adr [4];
  logic [AW-1:0] c_adr [4];
  logic [3:0]    s_neg;
  logic [3:0]    c_neg;

  always_comb begin
    logic [1:0]    quad;
    logic [AW-1:0] r_lo;
    logic [AW-1:0] r_hi;
    // latitude phases start at the south pole, three quarters round
    ph[0] = quo[0][PW-1:0] + PW'(3 * SINE_TABLE_DEPTH);
    ph[1] = quo[1][PW-1:0] + PW'(3 * SINE_TABLE_DEPTH);
    ph[2] = quo[2][PW-1:0];
    ph[3] = quo[3][PW-1:0];
    for (int k = 0; k < 4; k++) begin
      quad     = ph[k][PW-1:LG];
      r_lo     = AW'(ph[k][LG-1:0]);
      r_hi     = AW'(SINE_TABLE_DEPTH) - r_lo;
      s_adr[k] = quad[0] ? r_hi : r_lo;
      c_adr[k] = quad[0] ? r_lo : r_hi;
      s_neg[k] = quad[1];
      c_neg[k] = quad[1] ^ quad[0];
    end
  end

  logic [MAG_W-1:0] s_mag [4];
  logic [MAG_W-1:0] c_mag [4];

  for (genvar k = 0; k < 4; k++) begin : g_rom
    smcg_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_sin (
      .clk(clk), .en(adv), .addr(s_adr[k]), .data(s_mag[k]));
    smcg_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_cos (
      .clk(clk), .en(adv), .addr(c_adr[k]), .data(c_mag[k]));
  end

  meta_t      rom_meta_r;
  logic [3:0] s_neg_r;
  logic [3:0] c_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rom_meta_r <= '0;
    end else if (adv) begin
      rom_meta_r <= div_meta_r[DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_neg_r <= s_neg;
      c_neg_r <= c_neg;
    end
  end

  // -------------------------------------------------------------------------
  // Normal stage: corner c = {lon edge, lat edge}, sign and magnitude kept apart
  // -------------------------------------------------------------------------
  logic [MAG_W-1:0] nxm_nxt [4];
  logic [MAG_W-1:0] nym_nxt [4];
  logic [3:0]       nxs_nxt;
  logic [3:0]       nys_nxt;

  always_comb begin
    logic [31:0] px;
    logic [31:0] py;
    for (int c = 0; c < 4; c++) begin
      px = 32'(c_mag[2 + c/2]) * 32'(c_mag[c%2]) + 32'h4000;
      py = 32'(s_mag[2 + c/2]) * 32'(c_mag[c%2]) + 32'h4000;
      nxm_nxt[c] = px[MAG_W+14:15];
      nym_nxt[c] = py[MAG_W+14:15];
      nxs_nxt[c] = c_neg_r[2 + c/2] ^ c_neg_r[c%2];
      nys_nxt[c] = s_neg_r[2 + c/2] ^ c_neg_r[c%2];
    end
  end

  meta_t            nrm_meta_r;
  logic [MAG_W-1:0] nxm_r [4];
  logic [MAG_W-1:0] nym_r [4];
  logic [MAG_W-1:0] nzm_r [2];
  logic [3:0]       nxs_r;
  logic [3:0]       nys_r;
  logic [1:0]       nzs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_meta_r <= '0;
    end else if (adv) begin
      nrm_meta_r <= rom_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nxm_r    <= nxm_nxt;
      nym_r    <= nym_nxt;
      nxs_r    <= nxs_nxt;
      nys_r    <= nys_nxt;
      nzm_r[0] <= s_mag[0];
      nzm_r[1] <= s_mag[1];
      nzs_r    <= s_neg_r[1:0];
    end
  end

  // -------------------------------------------------------------------------
  // Position stage: scale by the radius, return to two's complement
  // -------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] scale(input logic [MAG_W-1:0] m,
                                             input logic             neg,
                                             input logic [RAD_W-1:0] rad);
    logic [31:0]      p;
    logic [POS_W-1:0] v;
    p = 32'(m) * 32'(rad) + 32'h4000;
    v = {1'b0, p[30:15]};
    return neg ? -v : v;
  endfunction

  function automatic logic [NRM_W-1:0] to_nrm(input logic [MAG_W-1:0] m,
                                              input logic             neg);
    logic [NRM_W-1:0] v;
    v = {1'b0, m};
    return neg ? -v : v;
  endfunction

  meta_t            pos_meta_r;
  logic [POS_W-1:0] px_r [4];
  logic [POS_W-1:0] py_r [4];
  logic [POS_W-1:0] pz_r [2];
  logic [NRM_W-1:0] nx_r [4];
  logic [NRM_W-1:0] ny_r [4];
  logic [NRM_W-1:0] nz_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_meta_r <= '0;
    end else if (adv) begin
      pos_meta_r <= nrm_meta_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        px_r[c] <= scale(nxm_r[c], nxs_r[c], radius_r);
        py_r[c] <= scale(nym_r[c], nys_r[c], radius_r);
        nx_r[c] <= to_nrm(nxm_r[c], nxs_r[c]);
        ny_r[c] <= to_nrm(nym_r[c], nys_r[c]);
      end
      for (int a = 0; a < 2; a++) begin
        pz_r[a] <= scale(nzm_r[a], nzs_r[a], radius_r);
        nz_r[a] <= to_nrm(nzm_r[a], nzs_r[a]);
      end
    end
  end

  // -------------------------------------------------------------------------
  // Emit stage: hold one cell, walk its vertex slots one per transaction
  // -------------------------------------------------------------------------
  logic [2:0]       e_idx_r;
  logic [2:0]       e_end_r;
  logic [POS_W-1:0] e_px_r [4];
  logic [POS_W-1:0] e_py_r [4];
  logic [POS_W-1:0] e_pz_r [2];
  logic [NRM_W-1:0] e_nx_r [4];
  logic [NRM_W-1:0] e_ny_r [4];
  logic [NRM_W-1:0] e_nz_r [2];
  logic [1:0]       corner;

  assign e_last = (e_idx_r == e_end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r   <= 1'b0;
      e_idx_r <= VTX_FIRST_LO;
      e_end_r <= VTX_SECOND_HI;
    end else if (adv) begin
      e_v_r   <= pos_meta_r.v;
      e_idx_r <= pos_meta_r.first  ? VTX_FIRST_LO  : VTX_SECOND_LO;
      e_end_r <= pos_meta_r.second ? VTX_SECOND_HI : VTX_FIRST_HI;
    end else if (out_ready) begin
      // advance to the next slot; the last one is handled by adv
      e_idx_r <= e_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_px_r <= px_r;
      e_py_r <= py_r;
      e_pz_r <= pz_r;
      e_nx_r <= nx_r;
      e_ny_r <= ny_r;
      e_nz_r <= nz_r;
    end
  end

  assign corner          = VTX_CORNER[e_idx_r];
  assign out_valid       = e_v_r;
  assign out_pos_x       = e_px_r[corner];
  assign out_pos_y       = e_py_r[corner];
  assign out_pos_z       = e_pz_r[corner[0]];
  assign out_norm_x      = e_nx_r[corner];
  assign out_norm_y      = e_ny_r[corner];
  assign out_norm_z      = e_nz_r[corner[0]];
  assign out_last_vertex = e_last;

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    e_v_r |-> (e_idx_r <= e_end_r))
    else $error("vertex slot beyond the end of the cell");

  a_mid_cell_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_vertex) |=> out_valid)
    else $error("cell ended without a last vertex");

  a_last_frees_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && out_last_vertex) |-> in_ready)
    else $error("pipe not released after the last vertex");

endmodule
